FILE: rtl/rphc_pkg.sv
// shared types and constants for the radar presence hold calibrator
package rphc_pkg;

  // request codes
  localparam logic [1:0] REQ_REPORT = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MOVE_DIST_MAX    = 3'd0;
  localparam logic [2:0] CFG_MOVE_ENERGY_MIN  = 3'd1;
  localparam logic [2:0] CFG_STILL_DIST_MAX   = 3'd2;
  localparam logic [2:0] CFG_STILL_ENERGY_MIN = 3'd3;
  localparam logic [2:0] CFG_LED_ALARM_ENABLE = 3'd4;
  localparam logic [2:0] CFG_HOLD_TIME_MS     = 3'd5;
  localparam logic [2:0] CFG_CALIB_WINDOW_MS  = 3'd6;

  // configuration reset values
  localparam logic [15:0] RST_MOVE_DIST_MAX    = 16'd600;
  localparam logic [7:0]  RST_MOVE_ENERGY_MIN  = 8'd50;
  localparam logic [15:0] RST_STILL_DIST_MAX   = 16'd600;
  localparam logic [7:0]  RST_STILL_ENERGY_MIN = 8'd50;
  localparam logic [15:0] RST_HOLD_TIME_MS     = 16'd2000;
  localparam logic [15:0] RST_CALIB_WINDOW_MS  = 16'd5000;

  // result kinds and calibration status codes
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_GATE   = 1'b1;

  localparam logic [1:0] CAL_IDLE    = 2'd0;
  localparam logic [1:0] CAL_RUNNING = 2'd1;
  localparam logic [1:0] CAL_DONE    = 2'd2;

  localparam logic [15:0] NEAR_LIMIT_CM = 16'd75;
  localparam logic [8:0]  MARGIN        = 9'd15;
  localparam logic [6:0]  THR_MIN       = 7'd20;
  localparam logic [6:0]  THR_MAX       = 7'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STAT,
    ST_GATES
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_status;
    logic load_gate;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_status;
    logic emit_gates;
    logic gates_pending;
    logic gate_last;
    logic slot_free;
  } dp_status_t;

  function automatic logic [6:0] clamp_thr(input logic [7:0] peak);
    logic [8:0] t;
    t = {1'b0, peak} + MARGIN;
    if (t < {2'b00, THR_MIN}) begin
      return THR_MIN;
    end else if (t > {2'b00, THR_MAX}) begin
      return THR_MAX;
    end else begin
      return t[6:0];
    end
  endfunction

endpackage

FILE: rtl/rphc_ctrl.sv
// controller state machine: accept, execute, emit status and gate results
module rphc_ctrl
  import rphc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (st.emit_status) begin
          state_next = ST_STAT;
        end else if (st.emit_gates) begin
          state_next = ST_GATES;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (st.slot_free) begin
          cmd.load_status = 1'b1;
          state_next = st.gates_pending ? ST_GATES : ST_IDLE;
        end
      end
      ST_GATES: begin
        if (st.slot_free) begin
          cmd.load_gate = 1'b1;
          if (st.gate_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rphc_dp.sv
// datapath: config registers, presence and calibration state, peaks, output register
module rphc_dp
  import rphc_pkg::*;
#(
  parameter int GATE_COUNT = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  st,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [31:0] time_ms,
  input  logic [15:0] moving_distance,
  input  logic [7:0]  moving_energy,
  input  logic [15:0] still_distance,
  input  logic [7:0]  still_energy,
  input  logic [3:0]  gate_index,
  input  logic [7:0]  gate_move_energy,
  input  logic [7:0]  gate_still_energy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        present,
  output logic        led_on,
  output logic [3:0]  gate,
  output logic [6:0]  moving_threshold,
  output logic [6:0]  still_threshold,
  output logic [1:0]  calib_status,
  output logic        last
);

  localparam int GIDX_W = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

  // configuration
  logic [15:0] move_dist_max;
  logic [7:0]  move_energy_min;
  logic [15:0] still_dist_max;
  logic [7:0]  still_energy_min;
  logic        led_alarm_enable;
  logic [15:0] hold_time_ms;
  logic [15:0] calib_window_ms;

  // latched input beat
  logic [1:0]  req_q;
  logic [31:0] time_q;
  logic [15:0] md_q;
  logic [7:0]  me_q;
  logic [15:0] sd_q;
  logic [7:0]  se_q;
  logic [3:0]  gidx_q;
  logic [7:0]  gme_q;
  logic [7:0]  gse_q;

  // block state
  logic        present_flag, present_flag_next;
  logic        led_state, led_state_next;
  logic        calibrating, calibrating_next;
  logic        calib_finished, calib_finished_next;
  logic [31:0] last_seen_ms, last_seen_ms_next;
  logic [31:0] calib_start_ms, calib_start_ms_next;
  logic [7:0]  moving_peak [GATE_COUNT];
  logic [7:0]  moving_peak_next [GATE_COUNT];
  logic [7:0]  still_peak [GATE_COUNT];
  logic [7:0]  still_peak_next [GATE_COUNT];

  logic              gates_pending;
  logic [GIDX_W-1:0] gate_cnt;

  logic [31:0] cal_elapsed;
  logic [31:0] seen_elapsed;
  logic        due;
  logic        mv_hit;
  logic        sv_hit;
  logic        is_report;
  logic        is_sample;
  logic        is_start;
  logic [1:0]  status_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_dist_max    <= RST_MOVE_DIST_MAX;
      move_energy_min  <= RST_MOVE_ENERGY_MIN;
      still_dist_max   <= RST_STILL_DIST_MAX;
      still_energy_min <= RST_STILL_ENERGY_MIN;
      led_alarm_enable <= 1'b0;
      hold_time_ms     <= RST_HOLD_TIME_MS;
      calib_window_ms  <= RST_CALIB_WINDOW_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOVE_DIST_MAX:    move_dist_max    <= cfg_data;
        CFG_MOVE_ENERGY_MIN:  move_energy_min  <= cfg_data[7:0];
        CFG_STILL_DIST_MAX:   still_dist_max   <= cfg_data;
        CFG_STILL_ENERGY_MIN: still_energy_min <= cfg_data[7:0];
        CFG_LED_ALARM_ENABLE: led_alarm_enable <= cfg_data[0];
        CFG_HOLD_TIME_MS:     hold_time_ms     <= cfg_data;
        CFG_CALIB_WINDOW_MS:  calib_window_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q  <= req_type;
      time_q <= time_ms;
      md_q   <= moving_distance;
      me_q   <= moving_energy;
      sd_q   <= still_distance;
      se_q   <= still_energy;
      gidx_q <= gate_index;
      gme_q  <= gate_move_energy;
      gse_q  <= gate_still_energy;
    end
  end

  assign cal_elapsed  = time_q - calib_start_ms;
  assign seen_elapsed = time_q - last_seen_ms;
  assign due    = calibrating && (cal_elapsed >= {16'd0, calib_window_ms});
  assign mv_hit = (md_q > NEAR_LIMIT_CM) && (md_q <= move_dist_max)
                  && (me_q >= move_energy_min);
  assign sv_hit = (sd_q > NEAR_LIMIT_CM) && (sd_q <= still_dist_max)
                  && (se_q >= still_energy_min);

  assign is_report = (req_q == REQ_REPORT);
  assign is_sample = (req_q == REQ_SAMPLE);
  assign is_start  = (req_q == REQ_START);

  always_comb begin
    present_flag_next   = present_flag;
    led_state_next      = led_state;
    calibrating_next    = calibrating;
    calib_finished_next = calib_finished;
    last_seen_ms_next   = last_seen_ms;
    calib_start_ms_next = calib_start_ms;
    for (int i = 0; i < GATE_COUNT; i++) begin
      moving_peak_next[i] = moving_peak[i];
      still_peak_next[i]  = still_peak[i];
    end
    if (cmd.exec) begin
      if (is_report) begin
        if (mv_hit || sv_hit) begin
          present_flag_next = 1'b1;
          last_seen_ms_next = time_q;
          if (led_alarm_enable) begin
            led_state_next = 1'b1;
          end
        end else if (seen_elapsed > {16'd0, hold_time_ms}) begin
          present_flag_next = 1'b0;
          led_state_next    = 1'b0;
        end
      end
      // each lane only looks at samples addressed to it
      if (is_sample && calibrating && !due) begin
        for (int i = 0; i < GATE_COUNT; i++) begin
          if (gidx_q == 4'(i)) begin
            if (gme_q > moving_peak[i]) moving_peak_next[i] = gme_q;
            if (gse_q > still_peak[i])  still_peak_next[i]  = gse_q;
          end
        end
      end
      if ((is_report || is_sample) && due) begin
        calibrating_next    = 1'b0;
        calib_finished_next = 1'b1;
      end
      if (is_start) begin
        calibrating_next    = 1'b1;
        calib_finished_next = 1'b0;
        calib_start_ms_next = time_q;
        for (int i = 0; i < GATE_COUNT; i++) begin
          moving_peak_next[i] = 8'd0;
          still_peak_next[i]  = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_flag   <= 1'b0;
      led_state      <= 1'b0;
      calibrating    <= 1'b0;
      calib_finished <= 1'b0;
      last_seen_ms   <= 32'd0;
      calib_start_ms <= 32'd0;
      for (int i = 0; i < GATE_COUNT; i++) begin
        moving_peak[i] <= 8'd0;
        still_peak[i]  <= 8'd0;
      end
    end else begin
      present_flag   <= present_flag_next;
      led_state      <= led_state_next;
      calibrating    <= calibrating_next;
      calib_finished <= calib_finished_next;
      last_seen_ms   <= last_seen_ms_next;
      calib_start_ms <= calib_start_ms_next;
      for (int i = 0; i < GATE_COUNT; i++) begin
        moving_peak[i] <= moving_peak_next[i];
        still_peak[i]  <= still_peak_next[i];
      end
    end
  end

  // gate sweep counter and pending flag, set up when the item executes
  always_ff @(posedge clk) begin
    if (rst) begin
      gates_pending <= 1'b0;
      gate_cnt      <= '0;
    end else if (cmd.exec) begin
      gates_pending <= st.emit_gates;
      gate_cnt      <= '0;
    end else if (cmd.load_gate) begin
      gate_cnt <= gate_cnt + 1'b1;
    end
  end

  assign st.emit_status   = cmd.exec && (is_report || is_start);
  assign st.emit_gates    = cmd.exec && (is_report || is_sample) && due;
  assign st.gates_pending = gates_pending;
  assign st.gate_last     = (gate_cnt == GIDX_W'(GATE_COUNT - 1));
  assign st.slot_free     = !out_valid || !out_stall;

  assign status_code = calibrating ? CAL_RUNNING : (calib_finished ? CAL_DONE : CAL_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_gate) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      kind             <= KIND_STATUS;
      gate             <= 4'd0;
      moving_threshold <= 7'd0;
      still_threshold  <= 7'd0;
      last             <= !gates_pending;
    end else if (cmd.load_gate) begin
      kind <= KIND_GATE;
      gate <= 4'(gate_cnt);
      // gate 0 is pinned to the top threshold
      if (gate_cnt == '0) begin
        moving_threshold <= THR_MAX;
        still_threshold  <= THR_MAX;
      end else begin
        moving_threshold <= clamp_thr(moving_peak[gate_cnt]);
        still_threshold  <= clamp_thr(still_peak[gate_cnt]);
      end
      last <= st.gate_last;
    end
    if (cmd.load_status || cmd.load_gate) begin
      present      <= present_flag;
      led_on       <= led_state;
      calib_status <= status_code;
    end
  end

endmodule

FILE: rtl/radar_presence_hold_calibrator.sv
// top level of the radar presence hold calibrator
//
// Input channel (in_valid / in_stall) carries one request per beat: a target
// report, a gate energy sample or a calibration start, each with a ms time.
// Output channel (out_valid / out_stall) returns results: a presence result
// for reports and starts, then one threshold per gate when a report or sample
// closes a calibration window. last marks the final result of a request.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// taken every cycle and belong only in idle periods.
// Timing: a request is taken in idle and executes in the cycle after; the
// controller then loads its results into the single output register, one
// result per cycle while the output is not stalled. The input stays closed
// until the last result of the request has been loaded.
// A stalled output holds its beat and the sweep waits; the next request can
// already be taken while the final result of the previous one sits unread.
// Reset clears presence, calibration state, peaks and restores the
// register defaults; no clearing pass is needed.
module radar_presence_hold_calibrator
  import rphc_pkg::*;
#(
  parameter int GATE_COUNT = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] time_ms,
  input  logic [15:0] moving_distance,
  input  logic [7:0]  moving_energy,
  input  logic [15:0] still_distance,
  input  logic [7:0]  still_energy,
  input  logic [3:0]  gate_index,
  input  logic [7:0]  gate_move_energy,
  input  logic [7:0]  gate_still_energy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        present,
  output logic        led_on,
  output logic [3:0]  gate,
  output logic [6:0]  moving_threshold,
  output logic [6:0]  still_threshold,
  output logic [1:0]  calib_status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  rphc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rphc_dp #(
    .GATE_COUNT (GATE_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .req_type           (req_type),
    .time_ms            (time_ms),
    .moving_distance    (moving_distance),
    .moving_energy      (moving_energy),
    .still_distance     (still_distance),
    .still_energy       (still_energy),
    .gate_index         (gate_index),
    .gate_move_energy   (gate_move_energy),
    .gate_still_energy  (gate_still_energy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .present            (present),
    .led_on             (led_on),
    .gate               (gate),
    .moving_threshold   (moving_threshold),
    .still_threshold    (still_threshold),
    .calib_status       (calib_status),
    .last               (last)
  );

endmodule

FILE: rtl/rphc_checker.sv
// port-level checks for the radar presence hold calibrator
module rphc_checker
  import rphc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [3:0] gate,
  input logic [6:0] moving_threshold,
  input logic [6:0] still_threshold,
  input logic [1:0] calib_status
);

  // one request at a time: the input closes right after a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_GATE) |->
      (moving_threshold >= THR_MIN && moving_threshold <= THR_MAX &&
       still_threshold >= THR_MIN && still_threshold <= THR_MAX))
    else $error("gate threshold out of range");

  a_gate_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_GATE) |-> calib_status == CAL_DONE)
    else $error("gate threshold without finished calibration");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_STATUS) |->
      (gate == 4'd0 && moving_threshold == 7'd0 && still_threshold == 7'd0))
    else $error("presence result carries gate fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output beat dropped");

endmodule

bind radar_presence_hold_calibrator rphc_checker u_rphc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .kind             (kind),
  .gate             (gate),
  .moving_threshold (moving_threshold),
  .still_threshold  (still_threshold),
  .calib_status     (calib_status)
);
